FILE: rtl/r2d_pkg.sv
// ----------------------------------------------------------------------------
// r2d_pkg
// Shared types, constants and the digit glyph lookup for the radix converter.
// ----------------------------------------------------------------------------
package r2d_pkg;

  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int DIV_STEP       = 8;   // quotient bits resolved per divide cycle
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEF_VALUE_BITS = 31;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // register index decoded from paddr
  localparam logic REG_RADIX = 1'b0;

  // per-item classification produced by the front end
  typedef struct packed {
    logic [RADIX_W-1:0] radix;   // effective radix, 2..16
    logic               pow2;    // radix is 2, 4, 8 or 16
    logic [2:0]         shift;   // log2 of radix when pow2
    logic [DIGIT_W-1:0] mask;    // radix - 1 when pow2
  } r2d_class_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 7'd48 + {3'b000, d};
    end else begin
      c = 7'd55 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

FILE: rtl/r2d_front.sv
// ----------------------------------------------------------------------------
// r2d_front
// Radix register with its APB port, and the input side: clamps the radix,
// sorts it into power-of-two or general, and queues each request.
// ----------------------------------------------------------------------------
module r2d_front
  import r2d_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // apb
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // request side
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] in_value,
  // queue write side
  input  logic                  q_full,
  output logic                  q_wr,
  output logic [VALUE_BITS-1:0] q_value,
  output r2d_class_t            q_class
);

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_nxt;
  logic [RADIX_W-1:0] eff;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    radix_nxt = radix_r;
    if (wr_en && reg_idx == REG_RADIX) begin
      radix_nxt = pwdata[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  assign prdata = (reg_idx == REG_RADIX) ? CFG_DATA_W'(radix_r) : '0;

  // out-of-range codes fold to the nearest legal radix
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff = RADIX_MAX;
    end else begin
      eff = radix_r;
    end
  end

  always_comb begin
    q_class.radix = eff;
    q_class.mask  = eff[DIGIT_W-1:0] - 4'd1;
    q_class.pow2  = 1'b1;
    q_class.shift = 3'd0;
    case (eff) inside
      5'd2:    q_class.shift = 3'd1;
      5'd4:    q_class.shift = 3'd2;
      5'd8:    q_class.shift = 3'd3;
      5'd16:   q_class.shift = 3'd4;
      default: q_class.pow2  = 1'b0;
    endcase
  end

  assign q_wr    = push & ~q_full;
  assign q_value = in_value;

endmodule

FILE: rtl/r2d_fifo.sv
// ----------------------------------------------------------------------------
// r2d_fifo
// Short queue of classified requests between the front end and the converter.
// ----------------------------------------------------------------------------
module r2d_fifo
  import r2d_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  r2d_class_t            wr_class,
  output logic                  full,
  input  logic                  rd,
  output logic [VALUE_BITS-1:0] rd_value,
  output r2d_class_t            rd_class,
  output logic                  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] val_r [QUEUE_DEPTH];
  r2d_class_t            cls_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [PTR_W-1:0]      rp_r, rp_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      val_r[wp_r] <= wr_value;
      cls_r[wp_r] <= wr_class;
    end
  end

  assign rd_value = val_r[rp_r];
  assign rd_class = cls_r[rp_r];

endmodule

FILE: rtl/r2d_back.sv
// ----------------------------------------------------------------------------
// r2d_back
// Converter: peels digits off least significant first (shift for power-of-two
// radices, iterative restoring divide otherwise) onto a digit stack, then
// replays the stack most significant first into the result register.
// ----------------------------------------------------------------------------
module r2d_back
  import r2d_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // queue read side
  input  logic                  q_empty,
  input  logic [VALUE_BITS-1:0] q_value,
  input  r2d_class_t            q_class,
  output logic                  q_rd,
  // result side
  input  logic                  pop,
  output logic                  empty,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  localparam int DIV_CYC  = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int WORK_W   = DIV_CYC * DIV_STEP;
  localparam int CYC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(DIV_CYC - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } r2d_state_t;

  r2d_state_t          state_r, state_nxt;
  logic [WORK_W-1:0]   work_r, work_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [CYC_W-1:0]    cyc_r, cyc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  r2d_class_t          cls_r;
  logic [DIGIT_W-1:0]  stk_r [VALUE_BITS];
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic [DIGIT_W-1:0]  div_rem;
  logic [WORK_W-1:0]   div_work;
  logic [DIGIT_W-1:0]  push_digit;
  logic                push_stk;
  logic                pop_stk;
  logic                load_out;
  logic                pop_ok;
  logic                digit_done;

  // DIV_STEP restoring steps on the narrow remainder
  always_comb begin
    logic [DIGIT_W-1:0]  r;
    logic [DIGIT_W:0]    t;
    logic [DIV_STEP-1:0] q;
    r = rem_r;
    q = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, work_r[WORK_W-1-i]};
      if (t >= cls_r.radix) begin
        t = t - cls_r.radix;
        q[DIV_STEP-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    div_rem  = r;
    div_work = (work_r << DIV_STEP) | WORK_W'(q);
  end

  assign pop_ok   = pop & out_valid_r;
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || pop_ok);
  assign q_rd     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt  = state_r;
    work_nxt   = work_r;
    rem_nxt    = rem_r;
    cyc_nxt    = cyc_r;
    cnt_nxt    = cnt_r;
    push_stk   = 1'b0;
    pop_stk    = 1'b0;
    push_digit = div_rem;
    digit_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          work_nxt  = WORK_W'(q_value);
          rem_nxt   = '0;
          cyc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cls_r.pow2) begin
          push_digit = work_r[DIGIT_W-1:0] & cls_r.mask;
          work_nxt   = work_r >> cls_r.shift;
          digit_done = 1'b1;
        end else begin
          work_nxt = div_work;
          rem_nxt  = div_rem;
          cyc_nxt  = cyc_r + 1'b1;
          if (cyc_r == CYC_LAST) begin
            rem_nxt    = '0;
            cyc_nxt    = '0;
            digit_done = 1'b1;
          end
        end
        if (digit_done) begin
          push_stk = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          // stop once the quotient runs out
          if (work_nxt == '0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          pop_stk = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (pop_ok) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cyc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cyc_r       <= cyc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (q_rd) begin
      cls_r <= q_class;
    end
    if (load_out) begin
      out_char_r <= digit_glyph(stk_r[0]);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  // digit stack: top of stack is always entry 0
  always_ff @(posedge clk) begin
    if (push_stk) begin
      stk_r[0] <= push_digit;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop_stk) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  assign empty          = ~out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

`ifndef SYNTH
  a_idle_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("digit stack not drained at end of request");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_BITS))
    else $error("digit stack overflow");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !cls_r.pow2) |-> ({1'b0, rem_r} < cls_r.radix))
    else $error("partial remainder not below radix");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("emitting from an empty digit stack");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && cnt_r == CNT_W'(1)) |=> (state_r == ST_IDLE))
    else $error("final digit loaded but converter did not finish");
`endif

endmodule

FILE: rtl/integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts non-negative integers to ASCII digit strings in a radix of 2..16.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full with in_value; a request is taken on a clock
//   edge with push high and full low. A two-entry queue holds requests while
//   the converter is busy.
//   Digits leave on empty/pop, most significant first, one ASCII character per
//   result ('0'-'9', 'A'-'F'), with out_last_digit set on the final digit.
//   Zero gives the single digit "0".
//   The radix register sits at APB address 0 (reset 10); codes 0/1 act as 2,
//   codes above 16 act as 16. Write it only while the block is idle.
// Processing per request:
//   power-of-two radix: digits are shifted off, then replayed;
//   other radices: digits come from restoring division (8 quotient bits
//   per cycle), then are replayed; requests pass the queue and hand-off
//   first. First digit appears after the divide phase.
// A stalled receiver holds the current digit and stops replay; the queue
// keeps taking requests until full. Reset empties the queue and the result
// register and sets the radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top
  import r2d_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // requests
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] in_value,
  // digits
  output logic                  empty,
  input  logic                  pop,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  logic                  q_wr;
  logic                  q_full;
  logic [VALUE_BITS-1:0] q_wr_value;
  r2d_class_t            q_wr_class;
  logic                  q_rd;
  logic                  q_empty;
  logic [VALUE_BITS-1:0] q_rd_value;
  r2d_class_t            q_rd_class;

  r2d_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .in_value (in_value),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_value  (q_wr_value),
    .q_class  (q_wr_class)
  );

  r2d_fifo #(.VALUE_BITS(VALUE_BITS)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_value (q_wr_value),
    .wr_class (q_wr_class),
    .full     (q_full),
    .rd       (q_rd),
    .rd_value (q_rd_value),
    .rd_class (q_rd_class),
    .empty    (q_empty)
  );

  r2d_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_value        (q_rd_value),
    .q_class        (q_rd_class),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  assign full = q_full;

endmodule
